// File: src/status_led_mode_controller_assert.svh
`ifndef STATUS_LED_MODE_CONTROLLER_ASSERT_SVH
`define STATUS_LED_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`ifndef SYNTHESIS
`define SLMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slmc check failed");
`else
`define SLMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

// next-cycle implication, checked outside reset
`ifndef SYNTHESIS
`define SLMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slmc check failed");
`else
`define SLMC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/slmc_pkg.sv
package slmc_pkg;

    localparam int TIME_BITS = 32;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_COLOR = 2'd1;
    localparam logic [1:0] OP_MODE  = 2'd2;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_USER   = 3'd1;
    localparam logic [2:0] MODE_LISTEN = 3'd2;
    localparam logic [2:0] MODE_OK     = 3'd3;
    localparam logic [2:0] MODE_NACK   = 3'd4;

    localparam logic [23:0] IDLE_RGB    = 24'h101010;
    localparam logic [23:0] LISTEN_RGB  = 24'h0000FF;
    localparam logic [23:0] OK_RGB      = 24'h00C800;
    localparam logic [23:0] NACK_RGB    = 24'hC80000;

    localparam logic [15:0] FLASH_TIME_RST  = 16'd200;
    localparam logic [15:0] LISTEN_TIME_RST = 16'd5760;

    localparam logic REG_FLASH_TIME  = 1'b0;
    localparam logic REG_LISTEN_TIME = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] color;
        logic [2:0]  mode;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    typedef struct packed {
        logic [15:0] flash_time;
        logic [15:0] listen_time;
    } t_cfg;

endpackage

// File: src/status_led_mode_controller.sv
// channel  | direction | handshake                   | beat
// ---------+-----------+-----------------------------+---------------------------
// in       | to block  | i_in_valid / o_in_stall     | i_in_item (op,color,mode,now)
// out      | from block| o_out_valid / i_out_stall   | o_out_item (red,green,blue)
// cfg      | to block  | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// one beat accepted every cycle while o_in_stall is low; a tick's drive passes through
// the input register, then the state update into the result register
// only a full result register held by i_out_stall stalls the input side
// synchronous reset restores registers, mode and colors at once, no clearing pass
`include "status_led_mode_controller_assert.svh"

module status_led_mode_controller
    import slmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        cfg;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    logic [23:0] r_out_drive;
    logic        has_result;
    logic [23:0] drive;
    logic        out_free;
    logic        fire;
    logic        is_tick;

    slmc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    slmc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in_item),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_drive      (drive)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // items with no drive pass through even when the output is blocked
    assign fire       = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign is_tick    = r_in_item.op == OP_TICK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && has_result) begin
            r_out_drive <= drive;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_item.red   = r_out_drive[23:16];
    assign o_out_item.green = r_out_drive[15:8];
    assign o_out_item.blue  = r_out_drive[7:0];

    `SLMC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall)
    `SLMC_ASSERT_NXT(a_tick_result, i_clk, i_rst_n, fire && is_tick, r_out_valid)
    `SLMC_ASSERT_NXT(a_no_phantom, i_clk, i_rst_n, fire && !is_tick && !i_out_stall, !r_out_valid)

endmodule

// File: src/slmc_regs.sv
module slmc_regs
    import slmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [15:0] r_flash_time;
    logic [15:0] r_listen_time;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_time  <= FLASH_TIME_RST;
            r_listen_time <= LISTEN_TIME_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_FLASH_TIME) begin
                r_flash_time <= pwdata[15:0];
            end else begin
                r_listen_time <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FLASH_TIME) begin
            prdata = {16'd0, r_flash_time};
        end else begin
            prdata = {16'd0, r_listen_time};
        end
    end

    assign o_cfg.flash_time  = r_flash_time;
    assign o_cfg.listen_time = r_listen_time;

endmodule

// File: src/slmc_core.sv
module slmc_core
    import slmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    output logic        o_has_result,
    output logic [23:0] o_drive
);

    logic [2:0]           r_mode,    n_mode;
    logic [23:0]          r_shown,   n_shown;
    logic [23:0]          r_pending, n_pending;
    logic                 r_pvalid,  n_pvalid;
    logic [TIME_BITS-1:0] r_entry,   n_entry;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 flash_done;
    logic                 listen_done;

    assign now_t       = TIME_BITS'(i_item.now_ms);
    assign elapsed     = now_t - r_entry;
    assign flash_done  = elapsed >= TIME_BITS'(i_cfg.flash_time);
    assign listen_done = elapsed >= TIME_BITS'(i_cfg.listen_time);

    always_comb begin
        n_mode       = r_mode;
        n_shown      = r_shown;
        n_pending    = r_pending;
        n_pvalid     = r_pvalid;
        n_entry      = r_entry;
        o_has_result = 1'b0;
        case (i_item.op)
            OP_COLOR: begin
                n_pending = i_item.color;
                if (r_mode == MODE_IDLE || r_mode == MODE_USER) begin
                    n_shown  = i_item.color;
                    n_pvalid = 1'b0;
                    n_mode   = MODE_USER;
                end else begin
                    n_pvalid = 1'b1;
                end
            end
            OP_MODE: begin
                n_mode  = i_item.mode;
                n_entry = now_t;
            end
            OP_TICK: begin
                o_has_result = 1'b1;
                if (r_mode == MODE_OK || r_mode == MODE_NACK) begin
                    if (flash_done) begin
                        if (r_pvalid) begin
                            n_shown  = r_pending;
                            n_pvalid = 1'b0;
                        end
                        n_mode = (n_shown == IDLE_RGB) ? MODE_IDLE : MODE_USER;
                    end
                end else if (r_mode == MODE_LISTEN) begin
                    if (listen_done) begin
                        n_mode  = MODE_NACK;
                        n_entry = now_t;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // drive follows the mode in force after the tick
    always_comb begin
        case (n_mode)
            MODE_LISTEN: o_drive = LISTEN_RGB;
            MODE_OK:     o_drive = OK_RGB;
            MODE_NACK:   o_drive = NACK_RGB;
            MODE_USER:   o_drive = n_shown;
            default:     o_drive = IDLE_RGB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_shown   <= IDLE_RGB;
            r_pending <= IDLE_RGB;
            r_pvalid  <= 1'b0;
            r_entry   <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_shown   <= n_shown;
            r_pending <= n_pending;
            r_pvalid  <= n_pvalid;
            r_entry   <= n_entry;
        end
    end

endmodule
